// ===== hw/rtl/ckst_pkg.sv =====
// Shared types and codes for the client keepalive session table.
// Used by ckst_cell and by the top level; depends on nothing else.
`default_nettype none

package ckst_pkg;

  // Default number of session slots
  localparam int SLOTS_DEF = 16;

  // Field widths
  localparam int ADDR_W = 48;
  localparam int ID_W   = 16;
  localparam int MS_W   = 20;
  localparam int ELAP_W = 16;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_DROP_AFTER = 2'd0;
  localparam logic [1:0] REG_PING_AFTER = 2'd1;
  localparam logic [1:0] REG_FIRST_ID   = 2'd2;

  // Register reset values
  localparam logic [MS_W-1:0] DROP_AFTER_RST = MS_W'(60000);
  localparam logic [MS_W-1:0] PING_AFTER_RST = MS_W'(1000);
  localparam logic [ID_W-1:0] FIRST_ID_RST   = ID_W'(1);

  // Request codes
  typedef enum logic [2:0] {
    REQ_TICK       = 3'd0,
    REQ_ALIVE      = 3'd1,
    REQ_CONNECT    = 3'd2,
    REQ_DISCONNECT = 3'd3,
    REQ_SHUTDOWN   = 3'd4
  } req_t;

  // Event codes
  typedef enum logic [2:0] {
    EV_ACCEPT        = 3'd0,
    EV_PING          = 3'd1,
    EV_DROP_TIMEOUT  = 3'd2,
    EV_DROP_SHUTDOWN = 3'd3,
    EV_LEFT          = 3'd4,
    EV_FULL          = 3'd5,
    EV_NOTHING       = 3'd6
  } ev_kind_t;

  // Request token that walks down the row of cells
  typedef struct packed {
    logic              active;
    req_t              req;
    logic [ADDR_W-1:0] addr;
    logic [ELAP_W-1:0] elapsed;
    logic              hit;        // some cell held the address
    logic [ID_W-1:0]   hit_id;     // id of that cell
    logic              free_found; // an earlier cell claimed the free slot
  } tok_t;

  // Event a cell or the tail logic offers to the output
  typedef struct packed {
    logic              valid;
    ev_kind_t          kind;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   id;
  } ev_t;

  // Timeout limits broadcast to every cell
  typedef struct packed {
    logic [MS_W-1:0] drop_after;
    logic [MS_W-1:0] ping_after;
  } lim_t;

  // Slot fill broadcast after a connect for a new client
  typedef struct packed {
    logic              commit;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   id;
  } fill_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ckst_cell.sv =====
// One session slot of the keepalive table: holds the slot state and
// processes the request token as it passes. Depends on ckst_pkg.
`default_nettype none

module ckst_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,      // whole row moves this cycle
  input  wire ckst_pkg::lim_t  lim,
  input  wire ckst_pkg::fill_t fill,
  input  wire ckst_pkg::tok_t  tok_in,
  output ckst_pkg::tok_t       tok_out,
  output ckst_pkg::ev_t        ev
);

  logic                        valid_r, valid_nxt;
  logic                        cand_r, cand_nxt;
  logic [ckst_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [ckst_pkg::ID_W-1:0]   id_r, id_nxt;
  logic [ckst_pkg::MS_W-1:0]   heard_r, heard_nxt;
  logic [ckst_pkg::MS_W-1:0]   pinged_r, pinged_nxt;
  ckst_pkg::tok_t              tok_r, tok_nxt;

  logic                        match;
  logic [ckst_pkg::MS_W:0]     heard_sum;
  logic [ckst_pkg::MS_W:0]     pinged_sum;
  logic [ckst_pkg::MS_W-1:0]   heard_sat;
  logic [ckst_pkg::MS_W-1:0]   pinged_sat;

  // Saturating aging adders
  assign heard_sum  = {1'b0, heard_r} + {5'd0, tok_in.elapsed};
  assign pinged_sum = {1'b0, pinged_r} + {5'd0, tok_in.elapsed};
  assign heard_sat  = heard_sum[ckst_pkg::MS_W] ? '1 : heard_sum[ckst_pkg::MS_W-1:0];
  assign pinged_sat = pinged_sum[ckst_pkg::MS_W] ? '1 : pinged_sum[ckst_pkg::MS_W-1:0];

  assign match = valid_r && (addr_r == tok_in.addr);

  // Request handling for the token sitting at this cell
  always_comb begin
    valid_nxt  = valid_r;
    cand_nxt   = cand_r;
    addr_nxt   = addr_r;
    id_nxt     = id_r;
    heard_nxt  = heard_r;
    pinged_nxt = pinged_r;
    tok_nxt    = tok_in;
    ev         = '0;
    ev.kind    = ckst_pkg::EV_NOTHING;
    ev.addr    = addr_r;
    ev.id      = id_r;

    if (tok_in.active) begin
      cand_nxt = (tok_in.req == ckst_pkg::REQ_CONNECT) && !valid_r && !tok_in.free_found;
      case (tok_in.req)
        ckst_pkg::REQ_TICK: begin
          if (valid_r) begin
            heard_nxt  = heard_sat;
            pinged_nxt = pinged_sat;
            if (heard_sat > lim.drop_after) begin
              valid_nxt = 1'b0;
              ev.valid  = 1'b1;
              ev.kind   = ckst_pkg::EV_DROP_TIMEOUT;
            end else if (pinged_sat > lim.ping_after) begin
              pinged_nxt = '0;
              ev.valid   = 1'b1;
              ev.kind    = ckst_pkg::EV_PING;
            end
          end
        end
        ckst_pkg::REQ_ALIVE: begin
          if (match) heard_nxt = '0;
        end
        ckst_pkg::REQ_CONNECT: begin
          if (match) begin
            heard_nxt      = '0;
            pinged_nxt     = '0;
            tok_nxt.hit    = 1'b1;
            tok_nxt.hit_id = id_r;
          end
          if (!valid_r) tok_nxt.free_found = 1'b1;
        end
        ckst_pkg::REQ_DISCONNECT: begin
          if (match) begin
            valid_nxt      = 1'b0;
            tok_nxt.hit    = 1'b1;
            tok_nxt.hit_id = id_r;
          end
        end
        ckst_pkg::REQ_SHUTDOWN: begin
          if (valid_r) begin
            valid_nxt = 1'b0;
            ev.valid  = 1'b1;
            ev.kind   = ckst_pkg::EV_DROP_SHUTDOWN;
          end
        end
        default: ;
      endcase
    end

    // Fill of the claimed free slot at the end of a connect
    if (fill.commit && cand_r) begin
      valid_nxt  = 1'b1;
      cand_nxt   = 1'b0;
      addr_nxt   = fill.addr;
      id_nxt     = fill.id;
      heard_nxt  = '0;
      pinged_nxt = '0;
    end
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      cand_r       <= 1'b0;
      tok_r.active <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_nxt;
      cand_r  <= cand_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // Slot payload
  always_ff @(posedge clk) begin
    if (adv) begin
      addr_r   <= addr_nxt;
      id_r     <= id_nxt;
      heard_r  <= heard_nxt;
      pinged_r <= pinged_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// ===== hw/rtl/client_keepalive_session_table_unit.sv =====
// Client keepalive session table: a row of SLOTS session cells walked
// by one request token. Depends on ckst_pkg and ckst_cell.
//
// Usage:
//   Requests enter on in_* (tuser = request code, tdata = address and
//   elapsed ms). Results leave on out_* (tuser = event code, tdata =
//   address and id, tlast = final result of the request). Limits and
//   the first client id are to be written on cfg_* only while the block
//   is idle; the block itself does not enforce this. An accepted request
//   walks the cells, one cell per cycle unless the row is frozen;
//   cell i reports its tick or shutdown event as the request passes it.
//   At the end of the row the tail logic gives the closing result, fills
//   a free slot for a new client, or reports a hit or a full table.
//   A further request is taken only once the last has reached the tail;
//   each result is registered in the output register.
//   Reset empties every slot, zeroes the id counter and loads the
//   default limits. When out_tready is low with a result held, the whole
//   row freezes until the result is taken.
`default_nettype none

module client_keepalive_session_table_unit #(
  parameter int SLOTS = ckst_pkg::SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [47:0] client_addr, [63:48] elapsed_ms
  input  wire logic [2:0]  in_tuser,   // [2:0] req_type
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [47:0] event_addr, [63:48] event_id
  output logic [2:0]       out_tuser,  // [2:0] event_kind
  output logic             out_tlast,
  // Configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  state_t                      state_r;
  ckst_pkg::tok_t              tok_r;
  logic                        out_valid_r;
  logic [63:0]                 out_data_r;
  logic [2:0]                  out_user_r;
  logic                        out_last_r;
  logic [ckst_pkg::ID_W-1:0]   offset_r;
  ckst_pkg::lim_t              lim_r;
  logic [ckst_pkg::ID_W-1:0]   first_id_r;

  ckst_pkg::tok_t              tok_link [SLOTS+1];
  ckst_pkg::ev_t               cell_ev  [SLOTS];
  logic [SLOTS-1:0]            cell_ev_vld;
  logic [SLOTS:0]              tok_act;

  ckst_pkg::tok_t              tail_tok;
  ckst_pkg::ev_t               tail_ev;
  logic                        tail_last;
  ckst_pkg::fill_t             fill;
  ckst_pkg::ev_t               ev_any;
  logic                        adv;
  logic                        in_acc;
  logic [ckst_pkg::ID_W-1:0]   new_id;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign new_id    = first_id_r + offset_r;

  // Row of session cells
  assign tok_link[0] = tok_r;
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    ckst_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .lim     (lim_r),
      .fill    (fill),
      .tok_in  (tok_link[g]),
      .tok_out (tok_link[g+1]),
      .ev      (cell_ev[g])
    );
    assign cell_ev_vld[g] = cell_ev[g].valid;
  end

  for (genvar g = 0; g <= SLOTS; g++) begin : g_act
    assign tok_act[g] = tok_link[g].active;
  end

  assign tail_tok = tok_link[SLOTS];

  // Tail of the row: closing results and new-client fill
  always_comb begin
    tail_ev      = '0;
    tail_ev.kind = ckst_pkg::EV_NOTHING;
    tail_ev.addr = tail_tok.addr;
    tail_last    = 1'b1;
    fill.commit  = 1'b0;
    fill.addr    = tail_tok.addr;
    fill.id      = new_id;
    if (tail_tok.active) begin
      case (tail_tok.req)
        ckst_pkg::REQ_TICK, ckst_pkg::REQ_SHUTDOWN: begin
          tail_ev.valid = 1'b1;
          tail_ev.addr  = '0;
        end
        ckst_pkg::REQ_CONNECT: begin
          tail_ev.valid = 1'b1;
          if (tail_tok.hit) begin
            tail_ev.kind = ckst_pkg::EV_ACCEPT;
            tail_ev.id   = tail_tok.hit_id;
          end else if (tail_tok.free_found) begin
            tail_ev.kind = ckst_pkg::EV_ACCEPT;
            tail_ev.id   = new_id;
            fill.commit  = adv;
          end else begin
            tail_ev.kind = ckst_pkg::EV_FULL;
          end
        end
        ckst_pkg::REQ_DISCONNECT: begin
          if (tail_tok.hit) begin
            tail_ev.valid = 1'b1;
            tail_ev.kind  = ckst_pkg::EV_LEFT;
            tail_ev.id    = tail_tok.hit_id;
          end
        end
        default: ;
      endcase
    end
  end

  // Merge events; at most one source is live per cycle
  always_comb begin
    ev_any = tail_ev;
    for (int i = 0; i < SLOTS; i++) begin
      if (cell_ev[i].valid) ev_any = cell_ev[i];
    end
  end

  // State, token entry, id counter and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tok_r.active <= 1'b0;
      out_valid_r  <= 1'b0;
      offset_r     <= '0;
    end else begin
      if (in_acc) begin
        state_r        <= ST_BUSY;
        tok_r.active   <= 1'b1;
        tok_r.req      <= ckst_pkg::req_t'(in_tuser);
        tok_r.addr     <= in_tdata[47:0];
        tok_r.elapsed  <= in_tdata[63:48];
        tok_r.hit      <= 1'b0;
        tok_r.hit_id   <= '0;
        tok_r.free_found <= 1'b0;
      end else if (adv) begin
        tok_r.active <= 1'b0;
      end
      if (adv && tail_tok.active) state_r <= ST_IDLE;
      if (fill.commit) offset_r <= offset_r + 1'b1;
      if (adv) begin
        out_valid_r <= ev_any.valid;
        out_data_r  <= {ev_any.id, ev_any.addr};
        out_user_r  <= ev_any.kind;
        out_last_r  <= tail_ev.valid && tail_last && !(|cell_ev_vld);
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.drop_after <= ckst_pkg::DROP_AFTER_RST;
      lim_r.ping_after <= ckst_pkg::PING_AFTER_RST;
      first_id_r       <= ckst_pkg::FIRST_ID_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ckst_pkg::REG_DROP_AFTER: lim_r.drop_after <= cfg_data;
        ckst_pkg::REG_PING_AFTER: lim_r.ping_after <= cfg_data;
        ckst_pkg::REG_FIRST_ID:   first_id_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // Only one request token is ever in the row
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_act))
    else $error("more than one request token in flight");

  // At most one cell reports an event in a cycle
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_ev_vld))
    else $error("several cells report at once");

  // No token sits in the row past the entry register while the block is idle
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !(|tok_act[SLOTS:1]))
    else $error("token in the row while idle");

  // An accepted request enters the row on the next cycle
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (tok_r.active && state_r == ST_BUSY))
    else $error("accepted request did not enter the row");

endmodule

`default_nettype wire

// ===== tb/client_keepalive_session_table_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for client_keepalive_session_table_unit: directed and random requests
// on the stream ports, every result checked against a behavioral session table.
// Depends on ckst_pkg and the unit's RTL.

module client_keepalive_session_table_unit_tb;
  import ckst_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  // a request must walk the whole row before the block is idle again; leave margin
  localparam int DRAIN_CYCLES = SLOTS + 8;
  localparam int HOLD_CYCLES = 400;
  // longest quiet stretch in a good run is the receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ADDR_POOL = 24;

  typedef struct {
    ev_kind_t          kind;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   id;
    logic              last;
  } session_event_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [47:0] client_addr, [63:48] elapsed_ms
  logic [2:0]  in_tuser;   // [2:0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [47:0] event_addr, [63:48] event_id
  logic [2:0]  out_tuser;  // [2:0] event_kind
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  client_keepalive_session_table_unit #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Session table as the bench sees it
  logic              live      [SLOTS];
  logic [ADDR_W-1:0] sess_addr [SLOTS];
  logic [ID_W-1:0]   sess_id   [SLOTS];
  logic [MS_W-1:0]   heard_ms  [SLOTS];
  logic [MS_W-1:0]   pinged_ms [SLOTS];
  logic [ID_W-1:0]   id_count;
  logic [MS_W-1:0]   drop_limit;
  logic [MS_W-1:0]   ping_limit;
  logic [ID_W-1:0]   first_id;
  session_event_t    pending_events [$];

  logic [ADDR_W-1:0] addr_pool [ADDR_POOL];
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int tick_span    = 1500;
  int mismatches   = 0;
  int quiet_cycles = 0;
  bit hold_req     = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Counter add that sticks at the top of the 20-bit range
  function automatic logic [MS_W-1:0] add_ms(logic [MS_W-1:0] acc, logic [ELAP_W-1:0] ms);
    logic [MS_W:0] sum;
    sum = (MS_W+1)'(acc) + (MS_W+1)'(ms);
    return sum[MS_W] ? '1 : sum[MS_W-1:0];
  endfunction

  function automatic void queue_event(ev_kind_t kind, logic [ADDR_W-1:0] addr,
                                      logic [ID_W-1:0] id, logic last);
    pending_events.push_back('{kind, addr, id, last});
  endfunction

  function automatic int find_session(logic [ADDR_W-1:0] addr);
    for (int i = 0; i < SLOTS; i++)
      if (live[i] && sess_addr[i] == addr) return i;
    return -1;
  endfunction

  // Apply one request to the table and queue the events it causes
  function automatic void predict_table(logic [2:0] req, logic [ADDR_W-1:0] addr,
                                        logic [ELAP_W-1:0] ms);
    int hit;
    int free_slot;
    hit = find_session(addr);
    free_slot = -1;
    case (req)
      REQ_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (live[i]) begin
            heard_ms[i] = add_ms(heard_ms[i], ms);
            pinged_ms[i] = add_ms(pinged_ms[i], ms);
            if (heard_ms[i] > drop_limit) begin
              live[i] = 1'b0;
              queue_event(EV_DROP_TIMEOUT, sess_addr[i], sess_id[i], 1'b0);
            end else if (pinged_ms[i] > ping_limit) begin
              pinged_ms[i] = '0;
              queue_event(EV_PING, sess_addr[i], sess_id[i], 1'b0);
            end
          end
        end
        queue_event(EV_NOTHING, '0, '0, 1'b1);
      end
      REQ_ALIVE: begin
        if (hit >= 0) heard_ms[hit] = '0;
      end
      REQ_CONNECT: begin
        if (hit >= 0) begin
          heard_ms[hit] = '0;
          pinged_ms[hit] = '0;
          queue_event(EV_ACCEPT, addr, sess_id[hit], 1'b1);
        end else begin
          // lowest free slot
          for (int i = SLOTS - 1; i >= 0; i--)
            if (!live[i]) free_slot = i;
          if (free_slot < 0) begin
            queue_event(EV_FULL, addr, '0, 1'b1);
          end else begin
            live[free_slot] = 1'b1;
            sess_addr[free_slot] = addr;
            sess_id[free_slot] = first_id + id_count;
            heard_ms[free_slot] = '0;
            pinged_ms[free_slot] = '0;
            id_count = id_count + 1'b1;
            queue_event(EV_ACCEPT, addr, sess_id[free_slot], 1'b1);
          end
        end
      end
      REQ_DISCONNECT: begin
        if (hit >= 0) begin
          live[hit] = 1'b0;
          queue_event(EV_LEFT, addr, sess_id[hit], 1'b1);
        end
      end
      REQ_SHUTDOWN: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (live[i]) begin
            live[i] = 1'b0;
            queue_event(EV_DROP_SHUTDOWN, sess_addr[i], sess_id[i], 1'b0);
          end
        end
        queue_event(EV_NOTHING, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // Random 48-bit address
  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(99) < 85) return addr_pool[$urandom_range(ADDR_POOL - 1)];
    return rand_addr();
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, field, got, want);
  endtask

  // Offer one request beat, with random gaps ahead of it
  task automatic send_req(logic [2:0] req, logic [ADDR_W-1:0] addr, logic [ELAP_W-1:0] ms);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {ms, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_table(req, addr, ms);
  endtask

  // Wait until every expected result is out and the row has gone quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [MS_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DROP_AFTER: drop_limit = value;
      REG_PING_AFTER: ping_limit = value;
      REG_FIRST_ID:   first_id = value[ID_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_limits(logic [MS_W-1:0] drop, logic [MS_W-1:0] ping,
                            logic [ID_W-1:0] first);
    settle();
    write_reg(REG_DROP_AFTER, drop);
    write_reg(REG_PING_AFTER, ping);
    write_reg(REG_FIRST_ID, MS_W'(first));
  endtask

  // Requests against an empty table, plus the codes the block ignores
  task automatic test_empty_table();
    send_req(REQ_TICK, '0, '0);
    send_req(REQ_SHUTDOWN, '0, '0);
    send_req(REQ_ALIVE, '1, '1);
    send_req(REQ_DISCONNECT, '1, '0);
    for (int r = 5; r < 8; r++) send_req(3'(r), '1, '1);
  endtask

  // Connect, reconnect, alive, ping, timeout, leave and shutdown
  task automatic test_sessions();
    send_req(REQ_CONNECT, '0, '1);
    send_req(REQ_CONNECT, '1, '0);
    send_req(REQ_CONNECT, '0, '0);        // known address keeps its id
    send_req(REQ_ALIVE, '1, '0);
    send_req(REQ_TICK, '0, ELAP_W'(1001)); // just past the ping limit
    send_req(REQ_TICK, '0, '1);            // silence past the drop limit
    send_req(REQ_CONNECT, 48'h5A5A_0000_1F90, '0);
    send_req(REQ_DISCONNECT, 48'h5A5A_0000_1F90, '0);
    send_req(REQ_CONNECT, 48'h0A00_0001_1F90, '0);
    send_req(REQ_SHUTDOWN, '0, '0);
  endtask

  // Mixed traffic, mostly on a small address pool so connects hit known clients
  task automatic random_requests(int count);
    int sent;
    int pick;
    logic [2:0] req;
    logic [ELAP_W-1:0] ms;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 25) req = REQ_TICK;
      else if (pick < 40) req = REQ_ALIVE;
      else if (pick < 75) req = REQ_CONNECT;
      else if (pick < 90) req = REQ_DISCONNECT;
      else if (pick < 94) req = REQ_SHUTDOWN;
      else req = 3'($urandom_range(5, 7));
      if ($urandom_range(3) == 0) ms = ELAP_W'($urandom_range(65535));
      else ms = ELAP_W'($urandom_range(tick_span));
      send_req(req, pick_addr(), ms);
      if (req <= REQ_SHUTDOWN) sent++;
    end
  endtask

  // Limits at the top of the range: counters saturate, nobody is pinged or dropped
  task automatic test_saturation();
    set_limits('1, '1, '1);
    send_req(REQ_SHUTDOWN, '0, '0);
    repeat (3) send_req(REQ_CONNECT, pick_addr(), '0);
    repeat (18) send_req(REQ_TICK, '0, '1);
    send_req(REQ_ALIVE, addr_pool[0], '0);
    send_req(REQ_TICK, '0, '1);
    send_req(REQ_SHUTDOWN, '0, '0);
  endtask

  // Limits of one ms: almost every tick drops or pings
  task automatic test_fast_timeouts();
    set_limits(MS_W'(1), MS_W'(1), ID_W'(16'h8000));
    tick_span = 4;
    random_requests(25);
  endtask

  // Receiver stalls while ticks full of pings keep arriving
  task automatic test_backpressure();
    set_limits(MS_W'(60000), MS_W'(1000), ID_W'(100));
    send_req(REQ_SHUTDOWN, '0, '0);
    repeat (12) send_req(REQ_CONNECT, rand_addr(), '0);
    hold_req = 1'b1;
    repeat (8) send_req(REQ_TICK, '0, ELAP_W'(1001));
    send_req(REQ_SHUTDOWN, '0, '0);
  endtask

  // Fill every slot, overflow, then free one and refill it
  task automatic test_table_full();
    logic [ADDR_W-1:0] held [SLOTS];
    settle();
    send_req(REQ_SHUTDOWN, '0, '0);
    for (int i = 0; i < SLOTS; i++) begin
      held[i] = rand_addr();
      send_req(REQ_CONNECT, held[i], '0);
    end
    send_req(REQ_CONNECT, rand_addr(), '0);
    send_req(REQ_CONNECT, held[SLOTS/2], '0);
    send_req(REQ_DISCONNECT, held[3], '0);
    send_req(REQ_CONNECT, rand_addr(), '0);
    send_req(REQ_CONNECT, rand_addr(), '0);
    send_req(REQ_SHUTDOWN, '0, '0);
  endtask

  // Result receiver with random stalls and one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Compare each result beat with the oldest expected event
  always @(posedge clk) begin : check_results
    session_event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, '0);
      end else begin
        want = pending_events.pop_front();
        if (out_tuser !== want.kind)
          report_mismatch("event_kind", 64'(out_tuser), 64'(want.kind));
        if (out_tdata[47:0] !== want.addr)
          report_mismatch("event_addr", 64'(out_tdata[47:0]), 64'(want.addr));
        if (out_tdata[63:48] !== want.id)
          report_mismatch("event_id", 64'(out_tdata[63:48]), 64'(want.id));
        if (out_tlast !== want.last)
          report_mismatch("tlast", 64'(out_tlast), 64'(want.last));
      end
    end
  end

  // Watchdog: too long without any beat on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Test sequence
  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      live[i] = 1'b0;
      sess_addr[i] = '0;
      sess_id[i] = '0;
      heard_ms[i] = '0;
      pinged_ms[i] = '0;
    end
    id_count = '0;
    drop_limit = DROP_AFTER_RST;
    ping_limit = PING_AFTER_RST;
    first_id = FIRST_ID_RST;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < ADDR_POOL; i++) addr_pool[i] = rand_addr();

    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles lightly, receiver heavily
    in_idle_pct = 21;
    out_idle_pct = 65;
    test_empty_table();
    test_sessions();
    tick_span = 1500;
    random_requests(20);

    // the other way round
    in_idle_pct = 65;
    out_idle_pct = 21;
    set_limits(MS_W'(3000), MS_W'(500), '0);
    tick_span = 800;
    random_requests(20);

    // no idling
    in_idle_pct = 0;
    out_idle_pct = 0;
    test_saturation();
    test_fast_timeouts();
    test_backpressure();
    test_table_full();
    settle();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
